/* rtl/gpio_controller_with_interrupts_assert.svh */
// Assertion macros shared by the GPIO controller RTL.
`ifndef GPIO_CONTROLLER_WITH_INTERRUPTS_ASSERT_SVH
`define GPIO_CONTROLLER_WITH_INTERRUPTS_ASSERT_SVH

`ifndef SYNTH
// Check that prop holds on every rising clock edge outside reset.
`define GPIOC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("gpio controller assertion failed");
// Check that cond in one cycle implies res in the next.
`define GPIOC_ASSERT_NEXT(label, clk, rst_n, cond, res) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
        else $error("gpio controller assertion failed");
`else
`define GPIOC_ASSERT(label, clk, rst_n, prop)
`define GPIOC_ASSERT_NEXT(label, clk, rst_n, cond, res)
`endif

`endif

/* rtl/gpioc_pkg.sv */
`timescale 1ns / 1ps
package gpioc_pkg;

    localparam int DATA_W      = 32;
    localparam int NUM_PINS_DF = 32;

    localparam int CMD_W = 2;
    localparam int IDX_W = 3;

    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

    localparam logic [IDX_W-1:0] REG_INPUT  = 3'd0;
    localparam logic [IDX_W-1:0] REG_OUTPUT = 3'd1;
    localparam logic [IDX_W-1:0] REG_DIR    = 3'd2;
    localparam logic [IDX_W-1:0] REG_ENABLE = 3'd3;
    localparam logic [IDX_W-1:0] REG_STATUS = 3'd4;
    localparam logic [IDX_W-1:0] REG_EDGE   = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [IDX_W-1:0]  reg_index;
        logic [DATA_W-1:0] write_data;
        logic [DATA_W-1:0] pin_levels;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [DATA_W-1:0] pin_drive_values;
        logic [DATA_W-1:0] pin_drive_enables;
        logic              irq_line;
    } t_result;

endpackage

/* rtl/gpioc_in_reg.sv */
`timescale 1ns / 1ps
module gpioc_in_reg
    import gpioc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

/* rtl/gpioc_core.sv */
`timescale 1ns / 1ps
module gpioc_core
    import gpioc_pkg::*;
#(
    parameter int NUM_PINS = NUM_PINS_DF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_item   i_item,
    output t_result o_result
);

    logic [NUM_PINS-1:0] r_prev, r_out, r_dir, r_en, r_pend, r_edge;
    logic [NUM_PINS-1:0] n_out, n_dir, n_en, n_pend, n_edge;
    logic [NUM_PINS-1:0] pins, wdata, rising, events, clear;
    logic [NUM_PINS-1:0] rdata;
    logic                is_wr;

    always_comb begin
        pins   = i_item.pin_levels[NUM_PINS-1:0];
        wdata  = i_item.write_data[NUM_PINS-1:0];
        rising = pins & ~r_prev;
        events = r_en & ((r_edge & rising) | (~r_edge & pins));
        is_wr  = (i_item.cmd == CMD_WRITE);

        n_out  = r_out;
        n_dir  = r_dir;
        n_en   = r_en;
        n_edge = r_edge;
        clear  = '0;
        if (is_wr) begin
            case (i_item.reg_index)
                REG_OUTPUT: n_out  = wdata;
                REG_DIR:    n_dir  = wdata;
                REG_ENABLE: n_en   = wdata;
                REG_STATUS: clear  = wdata;
                REG_EDGE:   n_edge = wdata;
                default:    ;
            endcase
        end
        // new event wins over a same-item clear
        n_pend = (r_pend & ~clear) | events;

        rdata = '0;
        if (i_item.cmd == CMD_READ) begin
            case (i_item.reg_index)
                REG_INPUT:  rdata = pins;
                REG_OUTPUT: rdata = r_out;
                REG_DIR:    rdata = r_dir;
                REG_ENABLE: rdata = r_en;
                REG_STATUS: rdata = r_pend;
                REG_EDGE:   rdata = r_edge;
                default:    rdata = '0;
            endcase
        end

        o_result.read_data         = DATA_W'(rdata);
        o_result.pin_drive_values  = DATA_W'(n_out);
        o_result.pin_drive_enables = DATA_W'(n_dir);
        o_result.irq_line          = |n_pend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_out  <= '0;
            r_dir  <= '0;
            r_en   <= '0;
            r_pend <= '0;
            r_edge <= '0;
        end else if (i_adv) begin
            r_prev <= pins;
            r_out  <= n_out;
            r_dir  <= n_dir;
            r_en   <= n_en;
            r_pend <= n_pend;
            r_edge <= n_edge;
        end
    end

endmodule

/* rtl/gpioc_out_reg.sv */
`timescale 1ns / 1ps
module gpioc_out_reg
    import gpioc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_taken,
    output logic    o_space,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // accept a new result while the held one leaves
    assign o_space  = !r_valid || i_taken;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

/* rtl/gpio_controller_with_interrupts.sv */
// Path: an accepted item waits in the input register, its result is formed
// combinationally and captured in the result register, then offered on m_axis.
// Throughput: one item per cycle while m_axis takes results; the input register
// and the result register each hold one item, and the state update sits between
// them. A stalled m_axis holds its result and, through the input register, stops s_axis.
// Reset: i_rst_n (synchronous, active low) empties both registers and clears
// all pin, output, direction, enable, status and edge-mode state to zero.
`timescale 1ns / 1ps
`include "gpio_controller_with_interrupts_assert.svh"
module gpio_controller_with_interrupts
    import gpioc_pkg::*;
#(
    parameter int NUM_PINS = NUM_PINS_DF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // [31:0] write_data, [63:32] pin_levels
    input  logic [63:0]   s_axis_tdata,
    // [1:0] cmd, [4:2] reg_index
    input  logic [4:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [31:0] read_data, [63:32] pin_drive_values, [95:64] pin_drive_enables,
    // [96] irq_line, [103:97] zero
    output logic [103:0]  m_axis_tdata
);

    localparam logic [DATA_W-1:0] PIN_MASK = DATA_W'((64'd1 << NUM_PINS) - 64'd1);

    t_item   s_item, q_item;
    t_result core_res, out_res;
    logic    q_valid, out_space, adv;
    logic    dir_wr;
    logic [DATA_W-1:0] dir_wdata;

    always_comb begin
        s_item.cmd        = s_axis_tuser[1:0];
        s_item.reg_index  = s_axis_tuser[4:2];
        s_item.write_data = s_axis_tdata[31:0];
        s_item.pin_levels = s_axis_tdata[63:32];
    end

    assign adv = q_valid && out_space;

    gpioc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_item  (s_item),
        .i_take  (adv),
        .o_ready (s_axis_tready),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    gpioc_core #(
        .NUM_PINS (NUM_PINS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_item   (q_item),
        .o_result (core_res)
    );

    gpioc_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (adv),
        .i_result (core_res),
        .i_taken  (m_axis_tready),
        .o_space  (out_space),
        .o_valid  (m_axis_tvalid),
        .o_result (out_res)
    );

    assign m_axis_tdata = {7'd0, out_res.irq_line, out_res.pin_drive_enables,
                           out_res.pin_drive_values, out_res.read_data};

    assign dir_wr    = adv && q_item.cmd == CMD_WRITE && q_item.reg_index == REG_DIR;
    assign dir_wdata = q_item.write_data & PIN_MASK;

    `GPIOC_ASSERT(a_adv_needs_item, i_clk, i_rst_n, !adv || q_valid)
    `GPIOC_ASSERT(a_hold_blocks_input, i_clk, i_rst_n, !(q_valid && !adv) || !s_axis_tready)
    `GPIOC_ASSERT_NEXT(a_adv_gives_result, i_clk, i_rst_n, adv, m_axis_tvalid)
    `GPIOC_ASSERT_NEXT(a_dir_write_shows, i_clk, i_rst_n, dir_wr, m_axis_tdata[95:64] == $past(dir_wdata))

endmodule
